// ----- rtl/core/binary_heap_priority_queue_defines.svh -----
// Assertion macros used by the heap queue sequencer
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BHPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// Next-cycle implication, disabled while reset is high
`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`endif

// ----- rtl/core/bhpq_pkg.sv -----
// Types, sizes and codes of the binary heap priority queue
package bhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int ACT_W    = 2;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 11;
   localparam int ENTRY_W  = KEY_W + TAG_W;

   typedef logic [ACT_W-1:0]  action_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam action_type ACT_PUSH = 2'd0;
   localparam action_type ACT_POP  = 2'd1;
   localparam action_type ACT_PEEK = 2'd2;
   localparam action_type ACT_NOP  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // One stored entry: key in the upper bits, tag below
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } entry_type;

   typedef struct packed {
      action_type action;
      entry_type  entry;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      entry_type          entry;
      logic [COUNT_W-1:0] count;
   } result_type;

   // Top level to sequencer
   typedef struct packed {
      logic start;
      logic out_free;
   } seq_ctl_type;

   // Sequencer to top level
   typedef struct packed {
      logic idle;
      logic done;
   } seq_sts_type;

endpackage

// ----- rtl/core/bhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module bhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bhpq_rank.sv -----
// Shared compare unit: decides whether entry a is served before entry b
module bhpq_rank (
   input  bhpq_pkg::entry_type a,
   input  bhpq_pkg::entry_type b,
   input  logic                larger_first,
   output logic                a_first
);
   import bhpq_pkg::*;

   logic key_gt;
   logic key_eq;

   assign key_gt = $signed(a.key) > $signed(b.key);
   assign key_eq = a.key == b.key;

   // Key order first, smaller tag breaks a tie
   always_comb begin
      priority if (!key_eq) begin
         a_first = larger_first ? key_gt : !key_gt;
      end else begin
         a_first = a.tag < b.tag;
      end
   end

endmodule

// ----- rtl/core/bhpq_seq.sv -----
// Heap sequencer: sifts entries through the heap RAM with one compare unit
`include "binary_heap_priority_queue_defines.svh"

module bhpq_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 larger_first,
   input  bhpq_pkg::cmd_type    cmd,
   input  bhpq_pkg::seq_ctl_type ctl,
   output bhpq_pkg::seq_sts_type sts,
   output bhpq_pkg::result_type result
);
   import bhpq_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISP     = 4'd1;
   localparam logic [3:0] S_UP_CHK   = 4'd2;
   localparam logic [3:0] S_UP_CMP   = 4'd3;
   localparam logic [3:0] S_POP_ROOT = 4'd4;
   localparam logic [3:0] S_POP_LAST = 4'd5;
   localparam logic [3:0] S_DN_RDL   = 4'd6;
   localparam logic [3:0] S_DN_RDR   = 4'd7;
   localparam logic [3:0] S_DN_CMPR  = 4'd8;
   localparam logic [3:0] S_PEEK     = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam int CW_W = IDX_W + 2;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   action_type       action_ff, action_in;
   entry_type        cur_ff, cur_in;
   entry_type        best_ff, best_in;
   logic             bsel_ff, bsel_in;
   status_type       status_ff, status_in;
   entry_type        res_ff, res_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type        rdata;

   entry_type        rank_a, rank_b;
   logic             a_first;

   logic [IDX_W-1:0] pos_m1;
   logic [IDX_W-1:0] parent;
   logic [CW_W-1:0]  left_w, right_w, count_w;
   logic             left_ok, right_ok;
   logic             full, empty;

   assign rdata = rd_raw;

   // Child and parent positions of the current hole
   assign pos_m1   = pos_ff - 1'b1;
   assign parent   = pos_m1 >> 1;
   assign left_w   = {1'b0, pos_ff, 1'b1};
   assign right_w  = left_w + 1'b1;
   assign count_w  = CW_W'(count_ff);
   assign left_ok  = left_w < count_w;
   assign right_ok = right_w < count_w;
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign empty    = count_ff == '0;

   // Pick the operands of the shared compare unit
   always_comb begin
      rank_a = rdata;
      rank_b = cur_ff;
      unique case (state_ff)
         S_UP_CMP: begin
            rank_a = cur_ff;
            rank_b = rdata;
         end
         S_DN_CMPR: begin
            rank_b = best_ff;
         end
         default: begin
         end
      endcase
   end

   bhpq_rank u_rank (
      .a            (rank_a),
      .b            (rank_b),
      .larger_first (larger_first),
      .a_first      (a_first)
   );

   bhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Sequence one operation: dispatch, sift up or down, report
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      action_in = action_ff;
      cur_in    = cur_ff;
      best_in   = best_ff;
      bsel_in   = bsel_ff;
      status_in = status_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               action_in = cmd.action;
               cur_in    = cmd.entry;
               state_in  = S_DISP;
            end
         end

         S_DISP: begin
            status_in = ST_OK;
            res_in    = '0;
            unique case (action_ff)
               ACT_PUSH: begin
                  if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     pos_in   = count_ff[IDX_W-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = S_UP_CHK;
                  end
               end
               ACT_POP, ACT_PEEK: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = (action_ff == ACT_POP) ? S_POP_ROOT : S_PEEK;
                  end
               end
               ACT_NOP: begin
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Climb: fetch the parent, or settle at the root
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               state_in = S_UP_CMP;
            end
         end

         // Move the parent down, or drop the new entry into the hole
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (a_first) begin
               wr_data  = rdata;
               pos_in   = parent;
               state_in = S_UP_CHK;
            end else begin
               state_in = S_DONE;
            end
         end

         S_PEEK: begin
            res_in   = rdata;
            state_in = S_DONE;
         end

         // Report the root and, if entries remain, fetch the last entry
         S_POP_ROOT: begin
            res_in   = rdata;
            count_in = count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(count_ff - 1'b1);
               state_in = S_POP_LAST;
            end
         end

         S_POP_LAST: begin
            cur_in   = rdata;
            pos_in   = '0;
            state_in = S_DN_RDL;
         end

         // Descend: fetch the left child, or settle at a leaf
         S_DN_RDL: begin
            if (left_ok) begin
               rd_en    = 1'b1;
               rd_addr  = left_w[IDX_W-1:0];
               state_in = S_DN_RDR;
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end

         // Left child against the moving entry
         S_DN_RDR: begin
            if (right_ok) begin
               best_in  = a_first ? rdata : cur_ff;
               bsel_in  = a_first;
               rd_en    = 1'b1;
               rd_addr  = right_w[IDX_W-1:0];
               state_in = S_DN_CMPR;
            end else begin
               wr_en = 1'b1;
               if (a_first) begin
                  wr_data  = rdata;
                  pos_in   = left_w[IDX_W-1:0];
                  state_in = S_DN_RDL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Right child against the better of the two so far
         S_DN_CMPR: begin
            wr_en = 1'b1;
            priority if (a_first) begin
               wr_data  = rdata;
               pos_in   = right_w[IDX_W-1:0];
               state_in = S_DN_RDL;
            end else if (bsel_ff) begin
               wr_data  = best_ff;
               pos_in   = left_w[IDX_W-1:0];
               state_in = S_DN_RDL;
            end else begin
               state_in = S_DONE;
            end
         end

         // Hold the result until the output register is free
         S_DONE: begin
            if (ctl.out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      action_ff <= action_in;
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      bsel_ff   <= bsel_in;
      status_ff <= status_in;
      res_ff    <= res_in;
   end

   assign sts.idle      = state_ff == S_IDLE;
   assign sts.done      = state_ff == S_DONE;
   assign result.status = status_ff;
   assign result.entry  = res_ff;
   assign result.count  = COUNT_W'(count_ff);

   `BHPQ_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `BHPQ_ASSERT_IMPL(a_up_not_root, clock, reset, state_ff == S_UP_CMP, pos_ff != '0)
   `BHPQ_ASSERT_NEXT(a_right_after_left, clock, reset, state_ff == S_DN_CMPR, state_ff == S_DN_RDL || state_ff == S_DONE)
   `BHPQ_ASSERT_NEXT(a_start_idle, clock, reset, sts.idle && ctl.start, state_ff == S_DISP)

endmodule

// ----- rtl/core/binary_heap_priority_queue.sv -----
// Binary heap priority queue: push, pop or peek one word per operation.
// One operation at a time: a new word is taken only after the last result is handed to the
// output register; a stalled result holds the input.
// Synchronous active-high reset empties the heap and selects larger-key-first order;
// the heap RAM holds no reset state and needs no clearing pass.
module binary_heap_priority_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bhpq_pkg::ACT_W-1:0]    req_action,
   input  logic signed [bhpq_pkg::KEY_W-1:0] req_key,
   input  logic [bhpq_pkg::TAG_W-1:0]    req_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bhpq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [bhpq_pkg::KEY_W-1:0] rsp_out_key,
   output logic [bhpq_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic [bhpq_pkg::COUNT_W-1:0]  rsp_count,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import bhpq_pkg::*;

   logic        larger_first_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   cmd_type     cmd;
   seq_ctl_type ctl;
   seq_sts_type sts;
   result_type  result;

   // Take a new word only while the sequencer is idle
   assign req_stall    = !sts.idle;
   assign cmd.action   = req_action;
   assign cmd.entry    = {req_key, req_tag};
   assign ctl.start    = req_valid && sts.idle;
   assign ctl.out_free = !rsp_valid_ff || !rsp_stall;

   bhpq_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .larger_first (larger_first_ff),
      .cmd          (cmd),
      .ctl          (ctl),
      .sts          (sts),
      .result       (result)
   );

   // Order register
   always_ff @(posedge clock) begin
      if (reset) begin
         larger_first_ff <= 1'b1;
      end else if (csr_wr_en) begin
         larger_first_ff <= csr_wr_data;
      end
   end

   // Output register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sts.done && ctl.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sts.done && ctl.out_free) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_out_key = rsp_ff.entry.key;
   assign rsp_out_tag = rsp_ff.entry.tag;
   assign rsp_count   = rsp_ff.count;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the binary heap priority queue: heap mirror and random stimulus
module tb_top;
   import bhpq_pkg::*;

   // Mirror of the heap: predicts one result word per accepted request word
   class heap_tracker;
      entry_type   slot [CAPACITY];
      int unsigned fill;
      bit          larger_first;
      result_type  pending_results[$];
      int unsigned mismatches;
      int unsigned words_by_action [4];
      int unsigned peak_fill;
      int unsigned refused_pushes;
      int unsigned empty_reads;

      function new();
         fill = 0;
         larger_first = 1'b1;
         mismatches = 0;
         peak_fill = 0;
         refused_pushes = 0;
         empty_reads = 0;
         foreach (words_by_action[i]) words_by_action[i] = 0;
      endfunction

      function void set_order(bit larger);
         larger_first = larger;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // True when entry a is served before entry b
      function bit ahead(entry_type a, entry_type b);
         if (a.key != b.key)
            return larger_first ? ($signed(a.key) > $signed(b.key))
                                : ($signed(a.key) < $signed(b.key));
         return a.tag < b.tag;
      endfunction

      function void note_request(action_type act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
         result_type want;
         entry_type  held;
         int unsigned pos, up, lft, best;
         bit         moving;
         want = '0;
         words_by_action[act]++;
         case (act)
            ACT_PUSH: begin
               if (fill >= CAPACITY) begin
                  want.status = ST_FULL;
                  refused_pushes++;
               end else begin
                  // append, then climb while ahead of the parent
                  held.key = k;
                  held.tag = t;
                  slot[fill] = held;
                  pos = fill;
                  fill++;
                  moving = 1'b1;
                  while (pos > 0 && moving) begin
                     up = (pos - 1) / 2;
                     if (ahead(slot[pos], slot[up])) begin
                        held = slot[pos];
                        slot[pos] = slot[up];
                        slot[up] = held;
                        pos = up;
                     end else begin
                        moving = 1'b0;
                     end
                  end
               end
            end
            ACT_POP, ACT_PEEK: begin
               if (fill == 0) begin
                  want.status = ST_EMPTY;
                  empty_reads++;
               end else begin
                  want.entry = slot[0];
                  if (act == ACT_POP) begin
                     // move the last entry to the root and sink it
                     fill--;
                     slot[0] = slot[fill];
                     pos = 0;
                     moving = (fill > 0);
                     while (moving) begin
                        lft = 2 * pos + 1;
                        best = pos;
                        if (lft < fill && ahead(slot[lft], slot[best]))
                           best = lft;
                        if (lft + 1 < fill && ahead(slot[lft + 1], slot[best]))
                           best = lft + 1;
                        if (best == pos) begin
                           moving = 1'b0;
                        end else begin
                           held = slot[pos];
                           slot[pos] = slot[best];
                           slot[best] = held;
                           pos = best;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         if (fill > peak_fill)
            peak_fill = fill;
         want.count = COUNT_W'(fill);
         pending_results = {pending_results, want};
      endfunction

      function void check_result(status_type st, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                 logic [COUNT_W-1:0] c);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d count %0d", st, c);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            mismatches++;
         end
         if (k !== want.entry.key) begin
            $error("out_key: expected %0d, got %0d", $signed(want.entry.key), $signed(k));
            mismatches++;
         end
         if (t !== want.entry.tag) begin
            $error("out_tag: expected %0d, got %0d", want.entry.tag, t);
            mismatches++;
         end
         if (c !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, c);
            mismatches++;
         end
      endfunction
   endclass

   localparam int HOLD_CYCLES = 300;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [ACT_W-1:0]   req_action;
   logic [KEY_W-1:0]   req_key;
   logic [TAG_W-1:0]   req_tag;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [STAT_W-1:0]  rsp_status;
   logic [KEY_W-1:0]   rsp_out_key;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [COUNT_W-1:0] rsp_count;
   logic               csr_wr_en;
   logic               csr_wr_data;

   heap_tracker book;
   bit          steady;
   bit          hold_off;
   int unsigned order_writes;
   int unsigned holds_done;

   binary_heap_priority_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_key     (req_key),
      .req_tag     (req_tag),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_out_key (rsp_out_key),
      .rsp_out_tag (rsp_out_tag),
      .rsp_count   (rsp_count),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keys: extremes, a narrow band for ties, or anything
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return 32'h0000_0001;
         endcase
      end
      if (r < 5)
         return KEY_W'($urandom_range(0, 15)) - 32'd8;
      return $urandom();
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      if ($urandom_range(0, 9) < 3)
         return TAG_W'($urandom_range(0, 3));
      return TAG_W'($urandom());
   endfunction

   // Offer one request word and hold it until accepted
   task automatic send_item(input action_type act, input logic [KEY_W-1:0] k,
                            input logic [TAG_W-1:0] t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      req_tag    <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(act, k, t);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
   endtask

   task automatic write_order(input bit larger);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= larger;
      @(posedge clock);
      book.set_order(larger);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      order_writes++;
   endtask

   // Random mix; no-op words do not count towards the total
   task automatic random_phase(input int words, input int push_pct, input int hold_at);
      int         sent;
      int         r;
      action_type act;
      sent = 0;
      while (sent < words) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            act = ACT_NOP;
         else if (r < 13)
            act = ACT_PEEK;
         else if (r < 13 + push_pct)
            act = ACT_PUSH;
         else
            act = ACT_POP;
         send_item(act, pick_key(), pick_tag());
         if (act != ACT_NOP) begin
            sent++;
            if (sent == hold_at)
               hold_off = 1'b1;
         end
      end
   endtask

   // Result side: random stall runs, plus one long hold-off on request
   initial begin : rsp_drive
      int run;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
            holds_done++;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            run = pick_gap();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(negedge clock);
            end
         end
      end
   end

   // Check each accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         book.check_result(rsp_status, rsp_out_key, rsp_out_tag, rsp_count);
   end

   // Guard against a hung run
   initial begin
      #4000000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      book = new();
      steady = 1'b0;
      hold_off = 1'b0;
      order_writes = 0;
      holds_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_NOP;
      req_key = '0;
      req_tag = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty heap reads and a no-op, larger key first after reset
      send_item(ACT_PEEK, 32'h0, 16'h0);
      send_item(ACT_POP, 32'hffff_ffff, 16'hffff);
      send_item(ACT_NOP, 32'h1234_5678, 16'h9abc);
      // key and tag extremes, ties on key and on key and tag
      send_item(ACT_PUSH, 32'h7fff_ffff, 16'h0000);
      send_item(ACT_PUSH, 32'h8000_0000, 16'hffff);
      send_item(ACT_PUSH, 32'h0000_0000, 16'h5555);
      send_item(ACT_PUSH, 32'hffff_ffff, 16'haaaa);
      send_item(ACT_PUSH, 32'h0000_0005, 16'h0007);
      send_item(ACT_PUSH, 32'h0000_0005, 16'h0003);
      send_item(ACT_PUSH, 32'h0000_0005, 16'h0003);
      send_item(ACT_PEEK, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_NOP, 32'h0, 16'h0);
      send_item(ACT_PEEK, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      // flip the order with entries still stored
      write_order(1'b0);
      send_item(ACT_PEEK, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);
      send_item(ACT_POP, 32'h0, 16'h0);

      // random traffic across order settings, one long hold-off on the result side
      random_phase(150, 55, 0);
      write_order(1'b1);
      random_phase(150, 60, 20);
      write_order(1'b0);
      steady = 1'b1;
      random_phase(150, 40, 0);
      steady = 1'b0;

      // drain under the other order, then read the empty heap
      write_order(1'b1);
      while (book.fill > 0) send_item(ACT_POP, pick_key(), pick_tag());
      send_item(ACT_POP, pick_key(), pick_tag());
      send_item(ACT_PEEK, pick_key(), pick_tag());

      write_order(1'b0);
      random_phase(100, 50, 0);
      write_order(1'b1);
      random_phase(50, 50, 0);

      wait_idle();
      repeat (60) @(negedge clock);
      $display("run covered %0d push, %0d pop, %0d peek and %0d no-op words",
               book.words_by_action[ACT_PUSH], book.words_by_action[ACT_POP],
               book.words_by_action[ACT_PEEK], book.words_by_action[ACT_NOP]);
      $display("peak fill %0d, %0d refused pushes, %0d empty reads, %0d order writes, %0d hold-offs",
               book.peak_fill, book.refused_pushes, book.empty_reads, order_writes, holds_done);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
